// ----- rtl/frs_pkg.sv -----
// ----------------------------------------------------------------------------
// frs_pkg
// Types and constants shared by the filter regeneration sequencer.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam logic [1:0] PH_MONITOR = 2'd0;
   localparam logic [1:0] PH_DRAIN   = 2'd1;
   localparam logic [1:0] PH_HEAT    = 2'd2;

   localparam logic [1:0] FAN_OFF  = 2'd0;
   localparam logic [1:0] FAN_IDLE = 2'd1;
   localparam logic [1:0] FAN_MAX  = 2'd2;

   localparam logic [7:0] PWR_OFF  = 8'd0;
   localparam logic [7:0] PWR_HALF = 8'd128;
   localparam logic [7:0] PWR_FULL = 8'd255;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CO2_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD_TICKS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAT_TICKS     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_TEMP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK_INTERVAL = 3'd4;

   typedef struct packed {
      logic [15:0]        co2_threshold;
      logic [23:0]        period_ticks;
      logic [15:0]        heat_ticks;
      logic signed [14:0] target_temp;
      logic [7:0]         check_interval;
   } frs_cfg_type;

   // sequencer state apart from the elapsed counter
   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] check_count;
      logic [1:0] fan;
      logic [7:0] heater;
   } frs_state_type;

endpackage

// ----- rtl/frs_csr.sv -----
// ----------------------------------------------------------------------------
// frs_csr
// Configuration register file, write only, with reset values.
// ----------------------------------------------------------------------------
module frs_csr
   import frs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output frs_cfg_type               cfg
);

   frs_cfg_type cfg_ff;
   frs_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CO2_THRESHOLD:  cfg_in.co2_threshold  = csr_wdata[15:0];
            CSR_PERIOD_TICKS:   cfg_in.period_ticks   = csr_wdata[23:0];
            CSR_HEAT_TICKS:     cfg_in.heat_ticks     = csr_wdata[15:0];
            CSR_TARGET_TEMP:    cfg_in.target_temp    = signed'(csr_wdata[14:0]);
            CSR_CHECK_INTERVAL: cfg_in.check_interval = csr_wdata[7:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.co2_threshold  <= 16'd1000;
         cfg_ff.period_ticks   <= 24'd3600;
         cfg_ff.heat_ticks     <= 16'd600;
         cfg_ff.target_temp    <= 15'sd320;
         cfg_ff.check_interval <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/frs_step.sv -----
// ----------------------------------------------------------------------------
// frs_step
// Next-state and result logic for one tick item.
// ----------------------------------------------------------------------------
module frs_step
   import frs_pkg::*;
#(
   parameter int ELAPSED_BITS = 24
)
(
   input  frs_cfg_type              cfg,
   input  frs_state_type            state,
   input  logic [ELAPSED_BITS-1:0]  elapsed,
   input  logic [15:0]              co2_ppm,
   input  logic                     co2_valid,
   input  logic signed [14:0]       temperature,
   output frs_state_type            state_next,
   output logic [ELAPSED_BITS-1:0]  elapsed_next,
   output logic [1:0]               shown_phase
);

   localparam int CMP_BITS = (ELAPSED_BITS > 24) ? ELAPSED_BITS : 24;

   logic                    co2_high;
   logic [7:0]              check_lim;
   logic [7:0]              check_sum;
   logic [7:0]              check_bumped;
   logic [ELAPSED_BITS-1:0] heat_base;
   logic [ELAPSED_BITS-1:0] heat_inc;
   logic [ELAPSED_BITS-1:0] mon_inc;
   logic                    heat_done;
   logic                    mon_done;
   logic [7:0]              heat_power;
   logic                    drain_exit;

   function automatic logic [ELAPSED_BITS-1:0] sat_inc(input logic [ELAPSED_BITS-1:0] v);
      logic [ELAPSED_BITS-1:0] r;
      r = v;
      if (v != {ELAPSED_BITS{1'b1}}) begin
         r = v + {{(ELAPSED_BITS-1){1'b0}}, 1'b1};
      end
      return r;
   endfunction

   always_comb begin
      co2_high     = !co2_valid || (co2_ppm > cfg.co2_threshold);
      check_lim    = (cfg.check_interval == 8'd0) ? 8'd1 : cfg.check_interval;
      check_sum    = state.check_count + 8'd1;
      check_bumped = (check_sum >= check_lim) ? 8'd0 : check_sum;
      drain_exit   = (state.phase == PH_DRAIN) && (state.check_count == 8'd0) && !co2_high;

      // heat from a drain exit starts from a cleared counter
      heat_base  = drain_exit ? '0 : elapsed;
      heat_inc   = sat_inc(heat_base);
      heat_done  = CMP_BITS'(heat_inc) >= CMP_BITS'(cfg.heat_ticks);
      heat_power = (temperature < cfg.target_temp) ? PWR_FULL : PWR_HALF;
      mon_inc    = sat_inc(elapsed);
      mon_done   = CMP_BITS'(mon_inc) >= CMP_BITS'(cfg.period_ticks);

      state_next   = state;
      elapsed_next = elapsed;
      shown_phase  = PH_MONITOR;

      if ((state.phase == PH_HEAT) || drain_exit) begin
         shown_phase       = PH_HEAT;
         state_next.fan    = FAN_OFF;
         state_next.heater = heat_power;
         if (heat_done) begin
            state_next.phase       = PH_MONITOR;
            state_next.check_count = 8'd0;
            elapsed_next           = '0;
         end else begin
            state_next.phase       = PH_HEAT;
            state_next.check_count = drain_exit ? 8'd0 : state.check_count;
            elapsed_next           = heat_inc;
         end
      end else if (state.phase == PH_DRAIN) begin
         shown_phase            = PH_DRAIN;
         state_next.fan         = FAN_MAX;
         state_next.heater      = PWR_OFF;
         state_next.check_count = check_bumped;
      end else begin
         // monitor; an unused phase code is handled the same way
         state_next.heater = PWR_OFF;
         if (state.check_count == 8'd0) begin
            state_next.fan = co2_high ? FAN_MAX : FAN_IDLE;
         end
         if (mon_done) begin
            state_next.phase       = PH_DRAIN;
            state_next.check_count = 8'd0;
            elapsed_next           = '0;
         end else begin
            state_next.phase       = PH_MONITOR;
            state_next.check_count = check_bumped;
            elapsed_next           = mon_inc;
         end
      end
   end

endmodule

// ----- rtl/filter_regen_sequencer.sv -----
// ----------------------------------------------------------------------------
// filter_regen_sequencer
// Filter regeneration sequencer: one tick item in, one fan/heater item out.
// ----------------------------------------------------------------------------
// Each req_ item is one one-second tick with a CO2 reading, its valid flag
// and the heater temperature. Each produces exactly one rsp_ item with the
// fan mode, heater power and the phase in which that tick was handled.
// Configuration is written through the csr_ port while no item is in flight;
// the user must keep to that, as the block itself does not enforce it.
//
// An accepted item waits in the input register. When it advances, the
// sequencer state is stepped and the result register loaded together, and
// rsp_valid rises. Throughput is one item per cycle while the receiver
// does not stall; the single state step between the two registers sets it.
//
// Reset clears both pipeline registers, puts the sequencer in monitor with
// counters cleared, fan off and heater off, and restores register defaults.
// When the receiver stalls, the result register holds its item; one more
// item is taken into the input register and then req_stall rises.
// ----------------------------------------------------------------------------
module filter_regen_sequencer
   import frs_pkg::*;
#(
   parameter int ELAPSED_BITS = 24
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [15:0]               req_co2_ppm,
   input  logic                      req_co2_valid,
   input  logic signed [14:0]        req_temperature,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_fan_mode,
   output logic [7:0]                rsp_heater_power,
   output logic [1:0]                rsp_phase,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   frs_cfg_type cfg;

   logic               in_valid_ff;
   logic [15:0]        in_ppm_ff;
   logic               in_co2_valid_ff;
   logic signed [14:0] in_temp_ff;

   frs_state_type           state_ff;
   frs_state_type           state_in;
   logic [ELAPSED_BITS-1:0] elapsed_ff;
   logic [ELAPSED_BITS-1:0] elapsed_in;
   logic [1:0]              shown_phase;

   logic       out_valid_ff;
   logic [1:0] out_fan_ff;
   logic [7:0] out_heater_ff;
   logic [1:0] out_phase_ff;

   logic advance;
   logic req_take;

   frs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   frs_step #(
      .ELAPSED_BITS (ELAPSED_BITS)
   ) u_step (
      .cfg          (cfg),
      .state        (state_ff),
      .elapsed      (elapsed_ff),
      .co2_ppm      (in_ppm_ff),
      .co2_valid    (in_co2_valid_ff),
      .temperature  (in_temp_ff),
      .state_next   (state_in),
      .elapsed_next (elapsed_in),
      .shown_phase  (shown_phase)
   );

   // move the held item on when the result register is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ppm_ff       <= req_co2_ppm;
         in_co2_valid_ff <= req_co2_valid;
         in_temp_ff      <= req_temperature;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_MONITOR;
         state_ff.check_count <= 8'd0;
         state_ff.fan         <= FAN_OFF;
         state_ff.heater      <= PWR_OFF;
         elapsed_ff           <= '0;
      end else if (advance) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_fan_ff    <= state_in.fan;
         out_heater_ff <= state_in.heater;
         out_phase_ff  <= shown_phase;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_fan_mode     = out_fan_ff;
   assign rsp_heater_power = out_heater_ff;
   assign rsp_phase        = out_phase_ff;

endmodule

// ----- rtl/frs_checker.sv -----
// ----------------------------------------------------------------------------
// frs_port_checker
// Port-level checks on the sequencer's result channel, bound to the top.
// ----------------------------------------------------------------------------
module frs_port_checker
   import frs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_fan_mode,
   input logic [7:0] rsp_heater_power,
   input logic [1:0] rsp_phase
);

   // heat ticks run with the fan off and the heater at full or half power
   a_heat_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_HEAT) |->
         (rsp_fan_mode == FAN_OFF) &&
         ((rsp_heater_power == PWR_FULL) || (rsp_heater_power == PWR_HALF)))
      else $error("heat item with wrong fan or heater drive");

   // drain ticks always blow at max with the heater off
   a_drain_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_DRAIN) |->
         (rsp_fan_mode == FAN_MAX) && (rsp_heater_power == PWR_OFF))
      else $error("drain item with wrong fan or heater drive");

   // monitor is always entered on a check, so the fan is never left off
   a_monitor_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_MONITOR) |->
         (rsp_heater_power == PWR_OFF) &&
         ((rsp_fan_mode == FAN_IDLE) || (rsp_fan_mode == FAN_MAX)))
      else $error("monitor item with wrong fan or heater drive");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_fan_mode) && $stable(rsp_heater_power) &&
         $stable(rsp_phase))
      else $error("stalled result item changed");

endmodule

bind filter_regen_sequencer frs_port_checker u_frs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_fan_mode     (rsp_fan_mode),
   .rsp_heater_power (rsp_heater_power),
   .rsp_phase        (rsp_phase)
);

// ----- sim/frs_checker.sv -----
// ----------------------------------------------------------------------------
// frs_checker
// Watches the tick and drive channels of the sequencer and checks every item.
// ----------------------------------------------------------------------------
// Keeps its own copy of the registers and of the sequencer state, steps it for
// every tick item taken by the block and queues the drive item it should give.
// Each drive item leaving the block is compared with the oldest one queued.
// The fault and pending counts go back to the testbench top.
// ----------------------------------------------------------------------------
module frs_checker
   import frs_pkg::*;
#(
   parameter int ELAPSED_BITS = 24
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [15:0]               req_co2_ppm,
   input  logic                      req_co2_valid,
   input  logic signed [14:0]        req_temperature,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_fan_mode,
   input  logic [7:0]                rsp_heater_power,
   input  logic [1:0]                rsp_phase,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fault_count,
   output int                        pending_count
);

   typedef struct packed {
      logic [1:0] fan_mode;
      logic [7:0] heater_power;
      logic [1:0] phase;
   } drive_type;

   frs_cfg_type             settings;
   frs_state_type           seq;
   logic [ELAPSED_BITS-1:0] elapsed;
   drive_type               drive_queue[$];
   int                      reported;

   function automatic logic [7:0] next_check(input logic [7:0] count);
      logic [7:0] lim;
      logic [7:0] nxt;
      // a zero interval behaves as one: every tick is a check
      lim = (settings.check_interval == 8'd0) ? 8'd1 : settings.check_interval;
      nxt = count + 8'd1;
      return (nxt >= lim) ? 8'd0 : nxt;
   endfunction

   task automatic step_heat(input logic signed [14:0] temp);
      seq.fan = FAN_OFF;
      seq.heater = ($signed(temp) < $signed(settings.target_temp)) ? PWR_FULL : PWR_HALF;
      if (~&elapsed) elapsed = elapsed + 1'b1;
      if (elapsed >= settings.heat_ticks) begin
         seq.phase = PH_MONITOR;
         elapsed = '0;
         seq.check_count = '0;
      end
   endtask

   task automatic predict_tick(input logic [15:0] ppm, input logic ok,
                               input logic signed [14:0] temp, output drive_type res);
      logic       air_bad;
      logic [1:0] shown;
      air_bad = !ok || (ppm > settings.co2_threshold);
      case (seq.phase)
         PH_HEAT: begin
            shown = PH_HEAT;
            step_heat(temp);
         end
         PH_DRAIN: begin
            // acceptable air at a check turns this very tick into the first heat tick
            if (seq.check_count == 8'd0 && !air_bad) begin
               seq.phase = PH_HEAT;
               elapsed = '0;
               seq.check_count = '0;
               shown = PH_HEAT;
               step_heat(temp);
            end else begin
               shown = PH_DRAIN;
               seq.fan = FAN_MAX;
               seq.heater = PWR_OFF;
               seq.check_count = next_check(seq.check_count);
            end
         end
         default: begin
            shown = PH_MONITOR;
            seq.phase = PH_MONITOR;
            seq.heater = PWR_OFF;
            if (seq.check_count == 8'd0) seq.fan = air_bad ? FAN_MAX : FAN_IDLE;
            seq.check_count = next_check(seq.check_count);
            if (~&elapsed) elapsed = elapsed + 1'b1;
            if (elapsed >= settings.period_ticks) begin
               seq.phase = PH_DRAIN;
               elapsed = '0;
               seq.check_count = '0;
            end
         end
      endcase
      res.fan_mode = seq.fan;
      res.heater_power = seq.heater;
      res.phase = shown;
   endtask

   always @(posedge clock) begin : watch
      drive_type want;
      drive_type got;
      if (reset) begin
         settings.co2_threshold = 16'd1000;
         settings.period_ticks = 24'd3600;
         settings.heat_ticks = 16'd600;
         settings.target_temp = 15'sd320;
         settings.check_interval = 8'd3;
         seq.phase = PH_MONITOR;
         seq.check_count = '0;
         seq.fan = FAN_OFF;
         seq.heater = PWR_OFF;
         elapsed = '0;
         drive_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CO2_THRESHOLD:  settings.co2_threshold = csr_wdata[15:0];
               CSR_PERIOD_TICKS:   settings.period_ticks = csr_wdata[23:0];
               CSR_HEAT_TICKS:     settings.heat_ticks = csr_wdata[15:0];
               CSR_TARGET_TEMP:    settings.target_temp = csr_wdata[14:0];
               CSR_CHECK_INTERVAL: settings.check_interval = csr_wdata[7:0];
               default: ;
            endcase
         end
         // compare before queueing, so a stray drive item cannot match this tick
         if (rsp_valid && !rsp_stall) begin
            got.fan_mode = rsp_fan_mode;
            got.heater_power = rsp_heater_power;
            got.phase = rsp_phase;
            if (drive_queue.size() == 0) begin
               fault_count++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected drive item at %0t: fan %0d heater %0d phase %0d",
                           $time, got.fan_mode, got.heater_power, got.phase);
               end
            end else begin
               want = drive_queue.pop_front();
               if (got.fan_mode !== want.fan_mode ||
                   got.heater_power !== want.heater_power ||
                   got.phase !== want.phase) begin
                  fault_count++;
                  if (reported < 10) begin
                     reported++;
                     $display({"mismatch at %0t: expected fan %0d heater %0d phase %0d,",
                               " got fan %0d heater %0d phase %0d"},
                              $time, want.fan_mode, want.heater_power, want.phase,
                              got.fan_mode, got.heater_power, got.phase);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_tick(req_co2_ppm, req_co2_valid, req_temperature, want);
            drive_queue.push_back(want);
         end
      end
      pending_count = drive_queue.size();
   end

endmodule

// ----- sim/filter_regen_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// filter_regen_sequencer_tb
// Stimulus and verdict for the filter regeneration sequencer.
// ----------------------------------------------------------------------------
// Sends directed tick items under the reset settings, then through the monitor,
// drain and heat phases with a short cycle and all-zero lengths, then random
// phases with fresh register settings, extremes among them. Both channels idle
// at random. The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module filter_regen_sequencer_tb
   import frs_pkg::*;
();

   localparam int ELAPSED_BITS  = 24;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_TICKS   = 100;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [15:0]               req_co2_ppm;
   logic                      req_co2_valid;
   logic signed [14:0]        req_temperature;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_fan_mode;
   logic [7:0]                rsp_heater_power;
   logic [1:0]                rsp_phase;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int                        fault_count;
   int                        pending_count;
   bit                        calm_req;
   bit                        calm_rsp;

   filter_regen_sequencer #(.ELAPSED_BITS(ELAPSED_BITS)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_co2_ppm      (req_co2_ppm),
      .req_co2_valid    (req_co2_valid),
      .req_temperature  (req_temperature),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fan_mode     (rsp_fan_mode),
      .rsp_heater_power (rsp_heater_power),
      .rsp_phase        (rsp_phase),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   frs_checker #(.ELAPSED_BITS(ELAPSED_BITS)) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_co2_ppm      (req_co2_ppm),
      .req_co2_valid    (req_co2_valid),
      .req_temperature  (req_temperature),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fan_mode     (rsp_fan_mode),
      .rsp_heater_power (rsp_heater_power),
      .rsp_phase        (rsp_phase),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fault_count      (fault_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // receiver: after each drive item it takes, raises rsp_stall for a random hold
   initial begin : receiver
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) hold = calm_rsp ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_tick(input logic [15:0] ppm, input logic ok,
                            input logic signed [14:0] temp);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_co2_ppm <= ppm;
      req_co2_valid <= ok;
      req_temperature <= temp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] thr, input logic [23:0] per,
                                 input logic [15:0] ht, input logic signed [14:0] targ,
                                 input logic [7:0] intv);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CO2_THRESHOLD;
      csr_wdata <= {8'd0, thr};
      @(negedge clock);
      csr_index <= CSR_PERIOD_TICKS;
      csr_wdata <= per;
      @(negedge clock);
      csr_index <= CSR_HEAT_TICKS;
      csr_wdata <= {8'd0, ht};
      @(negedge clock);
      csr_index <= CSR_TARGET_TEMP;
      csr_wdata <= {{9{targ[14]}}, targ};
      @(negedge clock);
      csr_index <= CSR_CHECK_INTERVAL;
      csr_wdata <= {16'd0, intv};
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [15:0]        thr;
      logic [23:0]        per;
      logic [15:0]        ht;
      logic signed [14:0] targ;
      logic [7:0]         intv;
      logic [15:0]        ppm;
      logic               ok;
      int                 bad;
      int                 t;
      int                 w;

      reset = 1'b1;
      req_valid = 1'b0;
      req_co2_ppm = '0;
      req_co2_valid = 1'b0;
      req_temperature = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm_req = 1'b0;
      calm_rsp = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: check every third tick
      send_tick(16'd1001, 1'b1, 15'sd0);
      send_tick(16'd0, 1'b1, 15'sd0);
      send_tick(16'd500, 1'b0, 15'sd0);
      wait_idle();

      // short cycle through every phase, threshold and target boundaries
      apply_settings(16'd1000, 24'd2, 16'd2, 15'sd320, 8'd1);
      send_tick(16'd1000, 1'b1, 15'sd0);
      send_tick(16'd65535, 1'b1, 15'sd0);
      send_tick(16'd500, 1'b0, 15'sd0);
      send_tick(16'd1001, 1'b1, 15'sd0);
      send_tick(16'd1000, 1'b1, -15'sd4096);
      send_tick(16'd0, 1'b1, 15'sd320);
      send_tick(16'd0, 1'b1, 15'sd16383);
      send_tick(16'd0, 1'b1, 15'sd319);
      send_tick(16'd0, 1'b1, 15'sd319);
      send_tick(16'd65535, 1'b0, 15'sd321);
      wait_idle();

      // zero interval, period and heat length: monitor and heat last one tick each
      apply_settings(16'd0, 24'd0, 16'd0, -15'sd1, 8'd0);
      send_tick(16'd0, 1'b1, -15'sd2);
      send_tick(16'd1, 1'b1, 15'sd0);
      send_tick(16'd0, 1'b1, -15'sd2);
      send_tick(16'd0, 1'b0, -15'sd1);
      send_tick(16'd0, 1'b1, -15'sd1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               thr = 16'd0;
               per = 24'hFFFFFF;
               ht = 16'hFFFF;
               targ = -15'sd4096;
               intv = 8'd255;
            end
            1: begin
               thr = 16'hFFFF;
               per = 24'd1;
               ht = 16'hFFFF;
               targ = 15'sd16383;
               intv = 8'd1;
            end
            2: begin
               thr = 16'hFFFF;
               per = 24'd1;
               ht = 16'd1;
               targ = -15'sd4096;
               intv = 8'd255;
            end
            default: begin
               thr = 16'($urandom_range(0, 65535));
               per = 24'($urandom_range(1, 40));
               ht = 16'($urandom_range(1, 30));
               t = int'($urandom_range(0, 20479)) - 4096;
               targ = t[14:0];
               if ($urandom_range(0, 3) == 0) intv = 8'($urandom_range(1, 255));
               else intv = 8'($urandom_range(1, 6));
            end
         endcase
         bad = $urandom_range(0, 6);
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         apply_settings(thr, per, ht, targ, intv);
         for (int n = 0; n < PHASE_TICKS; n++) begin
            ok = ($urandom_range(0, 15) != 0);
            w = $urandom_range(0, 15);
            if (w == 0) ppm = 16'($urandom_range(0, 65535));
            else if (w == 1) ppm = thr;
            else if ($urandom_range(0, 7) < bad && thr != 16'hFFFF)
               ppm = 16'($urandom_range(65535, int'(thr) + 1));
            else ppm = 16'($urandom_range(0, int'(thr)));
            if ($urandom_range(0, 1) == 0) t = int'(targ) + int'($urandom_range(0, 8)) - 4;
            else t = int'($urandom_range(0, 20479)) - 4096;
            if (t < -4096) t = -4096;
            if (t > 16383) t = 16383;
            send_tick(ppm, ok, t[14:0]);
         end
         wait_idle();
      end

      calm_rsp = 1'b0;
      for (w = 0; w < 2000 && pending_count != 0; w++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fault_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
